// File: rtl/core/yuy2rgb_pkg.sv
// Shared constants and the channel saturation function for the YUY2 to RGB converter.
package yuy2rgb_pkg;

	// Field widths of the pixel bytes.
	localparam int unsigned BYTE_W = 8;

	// Offset-removed luma and chroma values fit in 9 signed bits.
	localparam int unsigned DIFF_W = 9;

	// Folded coefficients, signed with 12 fraction bits.
	localparam int unsigned COEF_W = 15;
	localparam int unsigned FRAC_BITS = 12;

	localparam logic signed [COEF_W-1:0] K_LUMA = 15'sd4769;
	localparam logic signed [COEF_W-1:0] K_R_V  = 15'sd6571;
	localparam logic signed [COEF_W-1:0] K_G_U  = -15'sd1611;
	localparam logic signed [COEF_W-1:0] K_G_V  = -15'sd3344;
	localparam logic signed [COEF_W-1:0] K_B_U  = 15'sd8290;

	localparam logic [BYTE_W-1:0] LUMA_OFFSET   = 8'd16;
	localparam logic [BYTE_W-1:0] CHROMA_OFFSET = 8'd128;
	localparam logic [BYTE_W-1:0] CHAN_MAX      = 8'd255;

	// One product and one channel sum of up to three products.
	localparam int unsigned PROD_W = DIFF_W + COEF_W;
	localparam int unsigned SUM_W  = PROD_W + 2;

	// Negative sums give zero; otherwise floor to an integer and clamp at full scale.
	function automatic logic [BYTE_W-1:0] sat_channel(input logic signed [SUM_W-1:0] sum);
		logic [BYTE_W-1:0] res;
		if (sum[SUM_W-1]) begin
			res = '0;
		end else if (sum[SUM_W-2:FRAC_BITS+BYTE_W] != '0) begin
			res = CHAN_MAX;
		end else begin
			res = sum[FRAC_BITS+BYTE_W-1:FRAC_BITS];
		end
		return res;
	endfunction

endpackage

// File: rtl/core/yuy2_to_rgb_pixel_pair.sv
// Four-stage pipeline that turns one YUY2 macropixel into two saturated RGB pixels.
//
//  Channel   Signals                                        Direction  Handshake
//  --------  ---------------------------------------------  ---------  ---------------------------
//  input     luma_first, chroma_blue, luma_second,          in         taken when start && !busy
//            chroma_red
//  result    red_first, green_first, blue_first,            out        valid for one cycle on done
//            red_second, green_second, blue_second
//
// One item enters every clock cycle; busy is never raised, since every stage moves on each cycle.
// The result of an item shows up on done after these registered stages: offset removal,
// one multiplier per product, the channel sums, then saturation into the output register.
// The asynchronous reset clears only the valid bits; data registers carry no reset.
// The receiver cannot stall, so there is no back pressure anywhere in the pipeline.
module yuy2_to_rgb_pixel_pair (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [yuy2rgb_pkg::BYTE_W-1:0]    luma_first,
	input  logic [yuy2rgb_pkg::BYTE_W-1:0]    chroma_blue,
	input  logic [yuy2rgb_pkg::BYTE_W-1:0]    luma_second,
	input  logic [yuy2rgb_pkg::BYTE_W-1:0]    chroma_red,
	output logic                              done,
	output logic [yuy2rgb_pkg::BYTE_W-1:0]    red_first,
	output logic [yuy2rgb_pkg::BYTE_W-1:0]    green_first,
	output logic [yuy2rgb_pkg::BYTE_W-1:0]    blue_first,
	output logic [yuy2rgb_pkg::BYTE_W-1:0]    red_second,
	output logic [yuy2rgb_pkg::BYTE_W-1:0]    green_second,
	output logic [yuy2rgb_pkg::BYTE_W-1:0]    blue_second
);

	localparam int unsigned DW = yuy2rgb_pkg::DIFF_W;
	localparam int unsigned PW = yuy2rgb_pkg::PROD_W;
	localparam int unsigned SW = yuy2rgb_pkg::SUM_W;
	localparam int unsigned BW = yuy2rgb_pkg::BYTE_W;

	logic accept;

	// Stage 1: offsets removed.
	logic                 valid_s1;
	logic signed [DW-1:0] ly0_s1, ly1_s1, cb_s1, cr_s1;

	// Stage 2: the six products.
	logic                 valid_s2;
	logic signed [PW-1:0] py0_s2, py1_s2, prv_s2, pgu_s2, pgv_s2, pbu_s2;

	// Stage 3: channel sums in units of 2^-12.
	logic                 valid_s3;
	logic signed [SW-1:0] r0_s3, g0_s3, b0_s3, r1_s3, g1_s3, b1_s3;

	// Stage 4: saturated output bytes.
	logic                 valid_s4;
	logic [BW-1:0]        r0_s4, g0_s4, b0_s4, r1_s4, g1_s4, b1_s4;

	// The pipeline never holds, so the block is always ready.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Zero-extend each byte to nine bits, then subtract its offset; the result is signed.
	always_ff @(posedge clk) begin
		ly0_s1 <= $signed({1'b0, luma_first})  - $signed({1'b0, yuy2rgb_pkg::LUMA_OFFSET});
		ly1_s1 <= $signed({1'b0, luma_second}) - $signed({1'b0, yuy2rgb_pkg::LUMA_OFFSET});
		cb_s1  <= $signed({1'b0, chroma_blue}) - $signed({1'b0, yuy2rgb_pkg::CHROMA_OFFSET});
		cr_s1  <= $signed({1'b0, chroma_red})  - $signed({1'b0, yuy2rgb_pkg::CHROMA_OFFSET});
	end

	// Each product is 9 by 15 bits signed and fits 24 bits exactly; both operands are
	// sign-extended to 24 bits first so the multiply is carried out at full width.
	always_ff @(posedge clk) begin
		py0_s2 <= PW'(ly0_s1) * PW'(yuy2rgb_pkg::K_LUMA);
		py1_s2 <= PW'(ly1_s1) * PW'(yuy2rgb_pkg::K_LUMA);
		prv_s2 <= PW'(cr_s1) * PW'(yuy2rgb_pkg::K_R_V);
		pgu_s2 <= PW'(cb_s1) * PW'(yuy2rgb_pkg::K_G_U);
		pgv_s2 <= PW'(cr_s1) * PW'(yuy2rgb_pkg::K_G_V);
		pbu_s2 <= PW'(cb_s1) * PW'(yuy2rgb_pkg::K_B_U);
	end

	// Both pixels share the chroma products; only the luma term differs.
	always_ff @(posedge clk) begin
		r0_s3 <= SW'(py0_s2) + SW'(prv_s2);
		g0_s3 <= SW'(py0_s2) + SW'(pgu_s2) + SW'(pgv_s2);
		b0_s3 <= SW'(py0_s2) + SW'(pbu_s2);
		r1_s3 <= SW'(py1_s2) + SW'(prv_s2);
		g1_s3 <= SW'(py1_s2) + SW'(pgu_s2) + SW'(pgv_s2);
		b1_s3 <= SW'(py1_s2) + SW'(pbu_s2);
	end

	always_ff @(posedge clk) begin
		r0_s4 <= yuy2rgb_pkg::sat_channel(r0_s3);
		g0_s4 <= yuy2rgb_pkg::sat_channel(g0_s3);
		b0_s4 <= yuy2rgb_pkg::sat_channel(b0_s3);
		r1_s4 <= yuy2rgb_pkg::sat_channel(r1_s3);
		g1_s4 <= yuy2rgb_pkg::sat_channel(g1_s3);
		b1_s4 <= yuy2rgb_pkg::sat_channel(b1_s3);
	end

	assign done         = valid_s4;
	assign red_first    = r0_s4;
	assign green_first  = g0_s4;
	assign blue_first   = b0_s4;
	assign red_second   = r1_s4;
	assign green_second = g1_s4;
	assign blue_second  = b1_s4;

	// Every accepted item comes out on done.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##3 done)
		else $error("accepted item did not produce a result after four cycles");

	// No result appears on done without a matching accepted item.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ##3 !done)
		else $error("result strobe without a matching accepted item");

	// A negative red sum for the first pixel must come out as zero.
	a_clamp_low: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && r0_s3[SW-1]) |=> (done && red_first == '0))
		else $error("negative red sum not clamped to zero");

	// A green sum of the second pixel of 256 or more must come out as 255.
	a_clamp_high: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !g1_s3[SW-1] && g1_s3[SW-2:yuy2rgb_pkg::FRAC_BITS+BW] != '0)
		|=> (done && green_second == yuy2rgb_pkg::CHAN_MAX))
		else $error("overflowing green sum not clamped to full scale");

endmodule
